/* rtl/core/deq_pkg.sv */
package deq_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_LIST       = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_FRONT = 2'd0,
        RD_BACK  = 2'd1,
        RD_NEXT  = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    commit;
        logic    advance;
        logic    out_load;
        status_t out_status;
        logic    out_from_ram;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic    in_legal;
        action_t act;
        logic    empty;
        logic    full;
        logic    list_last;
        logic    out_free;
    } sts_t;

    // ring slot of base + off, both below DEPTH
    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W+1)'(DEPTH)) begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/core/deq_ram.sv */
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/deq_datapath.sv */
module deq_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  deq_pkg::cmd_t                        cmd,
    output deq_pkg::sts_t                        sts,
    input  logic [deq_pkg::ACTION_W-1:0]         s_action,
    input  logic signed [deq_pkg::DATA_W-1:0]    s_value,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [deq_pkg::STATUS_W-1:0]         m_status,
    output logic signed [deq_pkg::DATA_W-1:0]    m_item,
    output logic                                 m_last,
    output logic [deq_pkg::OCC_W-1:0]            m_occupancy
);

    localparam int AW = deq_pkg::ADDR_W;
    localparam int CW = deq_pkg::CNT_W;
    localparam int DW = deq_pkg::DATA_W;

    deq_pkg::action_t           act_reg, act_next;
    logic [DW-1:0]              value_reg, value_next;
    logic [AW-1:0]              front_reg, front_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic                       m_valid_reg, m_valid_next;
    deq_pkg::status_t           status_reg, status_next;
    logic [DW-1:0]              item_reg, item_next;
    logic                       last_reg, last_next;
    logic [deq_pkg::OCC_W-1:0]  occ_reg, occ_next;

    logic [AW-1:0] rd_off, rd_addr, wr_addr, pf_slot;
    logic [DW-1:0] rd_data;
    logic          wr_en;
    logic          is_push;

    assign is_push = (act_reg == deq_pkg::ACT_PUSH_FRONT) || (act_reg == deq_pkg::ACT_PUSH_BACK);

    assign sts.in_legal  = s_action inside {deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK,
                                            deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK,
                                            deq_pkg::ACT_LIST};
    assign sts.act       = act_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CW'(deq_pkg::DEPTH));
    assign sts.list_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        case (cmd.rd_sel)
            deq_pkg::RD_FRONT: rd_off = '0;
            deq_pkg::RD_BACK:  rd_off = AW'(count_reg - CW'(1));
            deq_pkg::RD_NEXT:  rd_off = idx_reg + AW'(1);
            default:           rd_off = '0;
        endcase
    end

    assign rd_addr = deq_pkg::slot_add(front_reg, rd_off);
    assign pf_slot = (front_reg == '0) ? AW'(deq_pkg::DEPTH - 1) : front_reg - AW'(1);
    assign wr_en   = cmd.commit && is_push;
    assign wr_addr = (act_reg == deq_pkg::ACT_PUSH_FRONT) ? pf_slot
                                                          : deq_pkg::slot_add(front_reg, AW'(count_reg));

    deq_ram #(
        .WIDTH (DW),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        act_next   = act_reg;
        value_next = value_reg;
        if (cmd.load) begin
            act_next   = deq_pkg::action_t'(s_action);
            value_next = s_value;
        end

        front_next = front_reg;
        count_next = count_reg;
        if (cmd.commit) begin
            case (act_reg)
                deq_pkg::ACT_PUSH_FRONT: begin
                    front_next = pf_slot;
                    count_next = count_reg + CW'(1);
                end
                deq_pkg::ACT_PUSH_BACK: begin
                    count_next = count_reg + CW'(1);
                end
                deq_pkg::ACT_POP_FRONT: begin
                    front_next = deq_pkg::slot_add(front_reg, AW'(1));
                    count_next = count_reg - CW'(1);
                end
                deq_pkg::ACT_POP_BACK: begin
                    count_next = count_reg - CW'(1);
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end

        idx_next = idx_reg;
        if (cmd.load) begin
            idx_next = '0;
        end else if (cmd.advance) begin
            idx_next = idx_reg + AW'(1);
        end

        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        item_next    = item_reg;
        last_next    = last_reg;
        occ_next     = occ_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            status_next  = cmd.out_status;
            item_next    = cmd.out_from_ram ? rd_data : '0;
            last_next    = cmd.out_last;
            occ_next     = deq_pkg::OCC_W'(count_next);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        item_reg   <= item_next;
        last_reg   <= last_next;
        occ_reg    <= occ_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_item      = item_reg;
    assign m_last      = last_reg;
    assign m_occupancy = occ_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(deq_pkg::DEPTH))
        else $error("entry count above depth");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !sts.full)
        else $error("write into a full ring");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !is_push) |-> !sts.empty)
        else $error("removal from an empty ring");

endmodule

/* rtl/core/deq_ctrl.sv */
module deq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  deq_pkg::sts_t sts,
    output deq_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    // unused action codes are dropped without a result
                    if (sts.in_legal) begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                case (sts.act)
                    deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
                        if (sts.out_free) begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = sts.full ? deq_pkg::ST_FULL : deq_pkg::ST_OK;
                            cmd.out_last   = 1'b1;
                            cmd.commit     = !sts.full;
                            state_next     = S_IDLE;
                        end
                    end
                    deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK, deq_pkg::ACT_LIST: begin
                        if (sts.empty) begin
                            if (sts.out_free) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = deq_pkg::ST_EMPTY;
                                cmd.out_last   = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = (sts.act == deq_pkg::ACT_POP_BACK) ? deq_pkg::RD_BACK
                                                                            : deq_pkg::RD_FRONT;
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                if (sts.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_status   = deq_pkg::ST_OK;
                    cmd.out_from_ram = 1'b1;
                    if (sts.act == deq_pkg::ACT_LIST) begin
                        cmd.out_last = sts.list_last;
                        if (sts.list_last) begin
                            state_next = S_IDLE;
                        end else begin
                            // fetch the next entry while this beat goes out
                            cmd.advance = 1'b1;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = deq_pkg::RD_NEXT;
                        end
                    end else begin
                        cmd.out_last = 1'b1;
                        cmd.commit   = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a waiting beat");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && sts.in_legal) |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    a_read_from_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && $past(state_reg) == S_EXEC) |-> $past(cmd.rd_en))
        else $error("read state entered without a fetch");

endmodule

/* rtl/core/double_ended_queue_unit.sv */
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_action[2:0], s_value[31:0] signed
// m_        out  m_valid/m_ready    m_status[1:0], m_item[31:0] signed, m_last, m_occupancy[6:0]
//
// one item at a time, taken in S_IDLE; a push, or a pop or list of an empty queue, passes S_EXEC
// a pop passes S_EXEC then S_READ, a list S_READ once per held entry, an unused action code neither
// pops and lists need S_READ because the read port of the 64-entry ring ram is registered
// aresetn clears front index, count and the output valid flag; ring contents are not cleared
// a new item is taken while the previous result beat still waits on m_ready
// a stalled m_ready holds the controller before it loads the next beat
module double_ended_queue_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [deq_pkg::ACTION_W-1:0]      s_action,
    input  logic signed [deq_pkg::DATA_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [deq_pkg::STATUS_W-1:0]      m_status,
    output logic signed [deq_pkg::DATA_W-1:0] m_item,
    output logic                              m_last,
    output logic [deq_pkg::OCC_W-1:0]         m_occupancy
);

    deq_pkg::cmd_t cmd;
    deq_pkg::sts_t sts;

    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    deq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_action    (s_action),
        .s_value     (s_value),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_status    (m_status),
        .m_item      (m_item),
        .m_last      (m_last),
        .m_occupancy (m_occupancy)
    );

endmodule
